>>> src/fuz_pkg.sv
// ----------------------------------------------------------------------------
// Fuzzy controller package
// Fixed set corner points, edge gains, rule table and reset values that are
// shared across the fuzzy controller design.
// ----------------------------------------------------------------------------
`default_nettype none

package fuz_pkg;

    // Number of fuzzy sets on each input.
    localparam int NUM_SETS = 5;

    // Inputs are clamped to plus or minus this many whole units.
    localparam int IN_CLAMP = 6;

    // Width of the output limit register and reset value of the limit.
    localparam int LIMIT_W     = 19;
    localparam int LIMIT_RESET = 409600;

    // Width of the output value.
    localparam int DRIVE_W = 20;

    // Width of the input fields.
    localparam int ERROR_W = 16;

    // Triangle corners (left, peak, right) in whole input units.
    localparam int TRI_PTS [NUM_SETS][3] = '{
        '{-6, -2, -1},
        '{-6, -1,  0},
        '{-1,  0,  1},
        '{ 0,  1,  6},
        '{ 1,  2,  6}
    };

    // Slope gains so that every set peaks at 20 times the unit scale.
    localparam int RISE_GAIN [NUM_SETS] = '{5, 4, 20, 20, 20};
    localparam int FALL_GAIN [NUM_SETS] = '{20, 20, 20, 4, 5};

    // Rule consequents, indexed by the set of input A and then of input B.
    localparam int RULE_TAB [NUM_SETS][NUM_SETS] = '{
        '{ 0,  0,  3,  6,  6},
        '{ 0,  0,  0,  3,  3},
        '{-3,  0,  0,  0,  3},
        '{-6, -3,  0,  0,  3},
        '{-6, -3, -3, -3,  0}
    };

endpackage

`default_nettype wire

>>> src/fuzzy_two_input_controller_top.sv
// ----------------------------------------------------------------------------
// Two-input fuzzy controller
// Clamps and grades two signed inputs against five triangular sets, forms
// the product-weighted average of the rule table and saturates the result.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake               Payload
//  s_        in         s_valid / s_ready       s_error_a, s_error_b
//  m_        out        m_valid / m_ready       m_drive_value
//  cfg_      in         cfg_valid / cfg_ready   cfg_data (output limit)
//
//  One input pair enters per cycle while the pipeline is not stalled. The
//  path runs through four arithmetic stages, FRAC_BITS + 4 stages of the
//  bit-per-stage divider and the output register.
//  Reset is synchronous on aresetn (active low) and clears all valid bits
//  and sets the output limit to 100.0.
//  Every stage holds its item while the stage after it is full and stalled,
//  and empty stages still fill, so bubbles close up under backpressure.
//
`default_nettype none

module fuzzy_two_input_controller_top #(
    parameter int FRAC_BITS = 12
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic signed [fuz_pkg::ERROR_W-1:0] s_error_a,
    input  wire logic signed [fuz_pkg::ERROR_W-1:0] s_error_b,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic signed [fuz_pkg::DRIVE_W-1:0]      m_drive_value,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [fuz_pkg::LIMIT_W-1:0]        cfg_data
);

    localparam int SCALE = 1 << FRAC_BITS;
    localparam int NS    = fuz_pkg::NUM_SETS;
    // Clamped input width, wide enough for the input field too.
    localparam int XW    = (FRAC_BITS + 5 > fuz_pkg::ERROR_W + 1) ?
                           FRAC_BITS + 5 : fuz_pkg::ERROR_W + 1;
    localparam int M_W   = FRAC_BITS + 5;   // one membership, up to 20*S
    localparam int SA_W  = FRAC_BITS + 6;   // membership sum, up to 36*S
    localparam int TW    = FRAC_BITS + 10;  // rule-weighted sum over B
    localparam int PW    = M_W + TW;        // one partial numerator
    localparam int NW    = PW + 3;          // full numerator
    localparam int DW    = 2 * SA_W;        // weight sum
    localparam int RW    = NW + 1;          // divider remainder
    localparam int QW    = FRAC_BITS + 4;   // quotient with one extra half bit
    localparam int LW    = (QW > fuz_pkg::LIMIT_W) ? QW : fuz_pkg::LIMIT_W;

    typedef logic [NS-1:0][M_W-1:0]        memb_t;
    typedef logic signed [NS-1:0][TW-1:0]  tsum_t;
    typedef logic signed [NS-1:0][PW-1:0]  part_t;

    // Grade one clamped input against all five sets.
    function automatic memb_t grade(input logic signed [XW-1:0] x);
        memb_t                 m;
        logic signed [XW-1:0]  a;
        logic signed [XW-1:0]  b;
        logic signed [XW-1:0]  c;
        logic signed [XW-1:0]  d;
        for (int i = 0; i < NS; i++) begin
            a = XW'(fuz_pkg::TRI_PTS[i][0] * SCALE);
            b = XW'(fuz_pkg::TRI_PTS[i][1] * SCALE);
            c = XW'(fuz_pkg::TRI_PTS[i][2] * SCALE);
            if (x >= a && x <= b) begin
                d    = x - a;
                m[i] = M_W'(d) * M_W'(fuz_pkg::RISE_GAIN[i]);
            end else if (x > b && x <= c) begin
                d    = c - x;
                m[i] = M_W'(d) * M_W'(fuz_pkg::FALL_GAIN[i]);
            end else begin
                m[i] = '0;
            end
        end
        return m;
    endfunction

    // Clamp one input to plus or minus six units.
    function automatic logic signed [XW-1:0] clamp_in(
        input logic signed [fuz_pkg::ERROR_W-1:0] v
    );
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] lim;
        x   = XW'(v);
        lim = XW'(fuz_pkg::IN_CLAMP * SCALE);
        if (x > lim) begin
            return lim;
        end else if (x < -lim) begin
            return -lim;
        end
        return x;
    endfunction

    // Configuration register; writes are always taken.
    logic [fuz_pkg::LIMIT_W-1:0] limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= fuz_pkg::LIMIT_W'(fuz_pkg::LIMIT_RESET);
        end else if (cfg_valid && cfg_ready) begin
            limit_reg <= cfg_data;
        end
    end

    // Stage readiness: a stage loads when it is empty or its successor loads.
    logic            rdy1, rdy2, rdy3, rdy4, rdy_out;
    logic [QW-1:0]   rdy_div;
    logic            v1_reg, v2_reg, v3_reg, v4_reg;
    logic [QW-1:0]   dv_reg;

    assign rdy_out = !m_valid || m_ready;
    assign rdy4    = !v4_reg || rdy_div[0];
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;

    // Stage 1: clamp and grade both inputs.
    memb_t ma1_reg, mb1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (rdy1) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            ma1_reg <= grade(clamp_in(s_error_a));
            mb1_reg <= grade(clamp_in(s_error_b));
        end
    end

    // Stage 2: membership sums and rule-weighted sums over input B.
    logic [SA_W-1:0] sa_next, sb_next, sa2_reg, sb2_reg;
    tsum_t           t_next, t2_reg;
    memb_t           ma2_reg;

    always_comb begin
        sa_next = '0;
        sb_next = '0;
        for (int i = 0; i < NS; i++) begin
            sa_next = sa_next + SA_W'(ma1_reg[i]);
            sb_next = sb_next + SA_W'(mb1_reg[i]);
        end
        for (int i = 0; i < NS; i++) begin
            t_next[i] = '0;
            for (int j = 0; j < NS; j++) begin
                t_next[i] = t_next[i]
                          + $signed(TW'(mb1_reg[j])) * TW'(fuz_pkg::RULE_TAB[i][j]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (rdy2) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            sa2_reg <= sa_next;
            sb2_reg <= sb_next;
            t2_reg  <= t_next;
            ma2_reg <= ma1_reg;
        end
    end

    // Stage 3: weight sum and partial numerators.
    logic [DW-1:0] den3_reg;
    part_t         p3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (rdy3) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            den3_reg <= sa2_reg * sb2_reg;
            for (int i = 0; i < NS; i++) begin
                p3_reg[i] <= $signed({1'b0, ma2_reg[i]}) * $signed(t2_reg[i]);
            end
        end
    end

    // Stage 4: full numerator, its sign and magnitude.
    logic signed [NW-1:0] num_next;
    logic [DW-1:0]        den4_reg;
    logic [NW-1:0]        mag4_reg;
    logic                 neg4_reg, zero4_reg;

    always_comb begin
        num_next = '0;
        for (int i = 0; i < NS; i++) begin
            num_next = num_next + NW'($signed(p3_reg[i]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (rdy4) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            den4_reg  <= den3_reg;
            neg4_reg  <= num_next < 0;
            mag4_reg  <= (num_next < 0) ? NW'(-num_next) : NW'(num_next);
            zero4_reg <= den3_reg == '0;
        end
    end

    // Divider: one quotient bit per stage. The first three stages produce
    // the integer bits against the shifted weight sum, the rest the
    // fraction bits plus one half bit for rounding.
    logic [RW-1:0] r_reg    [QW];
    logic [QW-1:0] q_reg    [QW];
    logic [DW-1:0] den_reg  [QW];
    logic          neg_reg  [QW];
    logic          zero_reg [QW];

    for (genvar k = 0; k < QW; k++) begin : g_div
        localparam int SH = (k < 3) ? 2 - k : 0;

        logic [RW-1:0] r_src, r_try, d_cmp, r_next;
        logic [QW-1:0] q_src;
        logic [DW-1:0] den_src;
        logic          neg_src, zero_src, v_src, rdy_nxt, bit_next;

        if (k == 0) begin : g_first
            assign r_src    = RW'(mag4_reg);
            assign q_src    = '0;
            assign den_src  = den4_reg;
            assign neg_src  = neg4_reg;
            assign zero_src = zero4_reg;
            assign v_src    = v4_reg;
        end else begin : g_rest
            assign r_src    = r_reg[k-1];
            assign q_src    = q_reg[k-1];
            assign den_src  = den_reg[k-1];
            assign neg_src  = neg_reg[k-1];
            assign zero_src = zero_reg[k-1];
            assign v_src    = dv_reg[k-1];
        end

        if (k == QW - 1) begin : g_last
            assign rdy_nxt = rdy_out;
        end else begin : g_mid
            assign rdy_nxt = rdy_div[k+1];
        end

        assign rdy_div[k] = !dv_reg[k] || rdy_nxt;

        // Compare and subtract for this quotient bit.
        always_comb begin
            r_try    = (k < 3) ? r_src : (r_src << 1);
            d_cmp    = RW'(den_src) << SH;
            bit_next = r_try >= d_cmp;
            r_next   = bit_next ? r_try - d_cmp : r_try;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[k] <= 1'b0;
            end else if (rdy_div[k]) begin
                dv_reg[k] <= v_src;
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy_div[k]) begin
                r_reg[k]    <= r_next;
                q_reg[k]    <= {q_src[QW-2:0], bit_next};
                den_reg[k]  <= den_src;
                neg_reg[k]  <= neg_src;
                zero_reg[k] <= zero_src;
            end
        end
    end

    // Output stage: round half away from zero, saturate and apply the sign.
    logic [QW-1:0]                    rnd;
    logic [fuz_pkg::LIMIT_W-1:0]      sat;
    logic signed [fuz_pkg::DRIVE_W-1:0] drive_next;
    logic                             m_valid_reg;
    logic signed [fuz_pkg::DRIVE_W-1:0] drive_reg;

    always_comb begin
        rnd = QW'((QW + 1)'(q_reg[QW-1]) + (QW + 1)'(1) >> 1);
        if (LW'(rnd) > LW'(limit_reg)) begin
            sat = limit_reg;
        end else begin
            sat = fuz_pkg::LIMIT_W'(rnd);
        end
        if (zero_reg[QW-1]) begin
            drive_next = '0;
        end else if (neg_reg[QW-1]) begin
            drive_next = -$signed(fuz_pkg::DRIVE_W'(sat));
        end else begin
            drive_next = $signed(fuz_pkg::DRIVE_W'(sat));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (rdy_out) begin
            m_valid_reg <= dv_reg[QW-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_out) begin
            drive_reg <= drive_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_drive_value = drive_reg;

`ifndef SYNTHESIS
    // An empty first stage always takes an input transfer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !v1_reg |-> s_ready)
        else $error("input not ready although the first stage is empty");

    // A full stage that cannot move on keeps its item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        v4_reg && !rdy4 |=> v4_reg)
        else $error("stalled item lost in the numerator stage");

    // An output that turns valid after an idle cycle, with the limit unchanged, stays within the limit in magnitude.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && $stable(limit_reg) && $past(m_valid) == 1'b0 |->
            (m_drive_value <= $signed({1'b0, limit_reg}))
            && (m_drive_value >= -$signed({1'b0, limit_reg})))
        else $error("output exceeds the configured limit");
`endif

endmodule

`default_nettype wire
